FILE: src/msba_pkg.sv
// ----------------------------------------------------------------------------
// msba_pkg
// Shared types and constants for the maximum-score assignment unit.
// ----------------------------------------------------------------------------
package msba_pkg;

    localparam int VALUE_W = 16;
    localparam int SCORE_W = 8;

    localparam logic [1:0] SCORE_WIN  = 2'd2;
    localparam logic [1:0] SCORE_TIE  = 2'd1;
    localparam logic [1:0] SCORE_LOSE = 2'd0;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COPY,
        ST_READ,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

FILE: src/msba_sorter.sv
// ----------------------------------------------------------------------------
// msba_sorter
// Row of insertion cells keeping values in descending order; shifts out at head.
// ----------------------------------------------------------------------------
module msba_sorter #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  logic              clk,
    input  logic              insert,
    input  logic              shift,
    input  logic [CW-1:0]     count,
    input  msba_pkg::value_t  din,
    output msba_pkg::value_t  head
);

    msba_pkg::value_t cell_reg [DEPTH];
    msba_pkg::value_t cell_next [DEPTH];
    logic [DEPTH-1:0] ge;

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ge[k] = (CW'(k) < count) && (cell_reg[k] >= din);
        end
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_next[k] = cell_reg[k];
            if (insert)
            begin
                if (ge[k])
                    cell_next[k] = cell_reg[k];
                else if (k == 0)
                    cell_next[k] = din;
                else if (ge[k-1])
                    cell_next[k] = din;
                else
                    cell_next[k] = cell_reg[k-1];
            end
            else if (shift && (k < DEPTH - 1))
            begin
                cell_next[k] = cell_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
    end

    assign head = cell_reg[0];

endmodule

FILE: src/msba_mem.sv
// ----------------------------------------------------------------------------
// msba_mem
// Sorted value store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module msba_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  msba_pkg::value_t  wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output msba_pkg::value_t  rdata_a,
    output msba_pkg::value_t  rdata_b
);

    msba_pkg::value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: src/max_score_bipartite_assignment_unit.sv
// Loading takes one request per cycle; after the last request the solve drains the
// sorted rows into the stores and runs the greedy matching (one read state and one
// decide state per matched pair), then presents the result.
// Throughput: one batch at a time; input is not ready from the last request until
// the result is taken. Reset clears control state only; stores are not cleared.
module max_score_bipartite_assignment_unit #(
    parameter int MAX_PAIRS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // first_value[15:0], second_value[31:16]
    input  logic        s_axis_tlast,  // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // total_score[7:0], overflow[8], zero[15:9]
);

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);

    msba_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] fh_reg, fh_next, ft_reg, ft_next;
    logic [AW-1:0] sh_reg, sh_next, st_reg, st_next;
    logic [msba_pkg::SCORE_W-1:0] total_reg, total_next;

    logic accept, insert, shift, we;
    logic [1:0] gain;
    msba_pkg::value_t f_head, s_head, fh_v, ft_v, sh_v, st_v;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign insert = accept && (cnt_reg < CW'(MAX_PAIRS));

    msba_sorter #(.DEPTH(MAX_PAIRS), .CW(CW)) u_sort_f (
        .clk(clk), .insert(insert), .shift(shift), .count(cnt_reg),
        .din(s_axis_tdata[15:0]), .head(f_head)
    );

    msba_sorter #(.DEPTH(MAX_PAIRS), .CW(CW)) u_sort_s (
        .clk(clk), .insert(insert), .shift(shift), .count(cnt_reg),
        .din(s_axis_tdata[31:16]), .head(s_head)
    );

    msba_mem #(.DEPTH(MAX_PAIRS), .AW(AW)) u_mem_f (
        .clk(clk), .we(we), .waddr(idx_reg), .wdata(f_head),
        .raddr_a(fh_reg), .raddr_b(ft_reg), .rdata_a(fh_v), .rdata_b(ft_v)
    );

    msba_mem #(.DEPTH(MAX_PAIRS), .AW(AW)) u_mem_s (
        .clk(clk), .we(we), .waddr(idx_reg), .wdata(s_head),
        .raddr_a(sh_reg), .raddr_b(st_reg), .rdata_a(sh_v), .rdata_b(st_v)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        fh_next    = fh_reg;
        ft_next    = ft_reg;
        sh_next    = sh_reg;
        st_next    = st_reg;
        total_next = total_reg;
        shift      = 1'b0;
        we         = 1'b0;
        gain       = msba_pkg::SCORE_LOSE;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            msba_pkg::ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    if (insert)
                        cnt_next = cnt_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (s_axis_tlast)
                    begin
                        total_next = '0;
                        idx_next   = '0;
                        if (cnt_next == '0)
                            state_next = msba_pkg::ST_OUT;
                        else
                            state_next = msba_pkg::ST_COPY;
                    end
                end
            end
            msba_pkg::ST_COPY:
            begin
                // drain the sorted rows head first into the stores
                we    = 1'b1;
                shift = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (CW'(idx_reg) == cnt_reg - 1'b1)
                begin
                    fh_next  = '0;
                    sh_next  = '0;
                    ft_next  = AW'(cnt_reg - 1'b1);
                    st_next  = AW'(cnt_reg - 1'b1);
                    rem_next = cnt_reg;
                    state_next = msba_pkg::ST_READ;
                end
            end
            msba_pkg::ST_READ:
            begin
                state_next = msba_pkg::ST_DECIDE;
            end
            msba_pkg::ST_DECIDE:
            begin
                if (fh_v > sh_v)
                begin
                    gain = msba_pkg::SCORE_WIN;
                    fh_next = fh_reg + 1'b1;
                    sh_next = sh_reg + 1'b1;
                end
                else if (fh_v < sh_v)
                begin
                    // weakest first entry is sacrificed against the strongest
                    ft_next = ft_reg - 1'b1;
                    sh_next = sh_reg + 1'b1;
                end
                else if (ft_v > st_v)
                begin
                    gain = msba_pkg::SCORE_WIN;
                    ft_next = ft_reg - 1'b1;
                    st_next = st_reg - 1'b1;
                end
                else
                begin
                    if (ft_v > sh_v)
                        gain = msba_pkg::SCORE_WIN;
                    else if (ft_v == sh_v)
                        gain = msba_pkg::SCORE_TIE;
                    ft_next = ft_reg - 1'b1;
                    sh_next = sh_reg + 1'b1;
                end
                total_next = total_reg + msba_pkg::SCORE_W'(gain);
                rem_next   = rem_reg - 1'b1;
                if (rem_reg == CW'(1))
                    state_next = msba_pkg::ST_OUT;
                else
                    state_next = msba_pkg::ST_READ;
            end
            msba_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = msba_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = msba_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msba_pkg::ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        fh_reg    <= fh_next;
        ft_reg    <= ft_next;
        sh_reg    <= sh_next;
        st_reg    <= st_next;
        total_reg <= total_next;
    end

    assign m_axis_tdata = {7'd0, ovf_reg, total_reg};

    a_hs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PAIRS))
        else $error("pair count beyond capacity");

    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msba_pkg::ST_DECIDE) |-> (rem_reg != '0))
        else $error("decide step with no pairs left");

endmodule

FILE: tb/max_score_bipartite_assignment_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_score_bipartite_assignment_unit_tb
// Streams batches of value pairs into the assignment unit and checks each total
// and overflow flag. The expected total comes from a sorted two-pointer greedy
// matching. Runs through several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module max_score_bipartite_assignment_unit_tb;

    localparam int MAX_PAIRS  = 64;
    localparam int WDOG_LIMIT = 20000;
    localparam int SCORE_W    = msba_pkg::SCORE_W;

    typedef msba_pkg::value_t value_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } total_t;

    typedef struct {
        value_t  fv;
        value_t  sv;
        bit      last;
        bit      typed;
        total_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    max_score_bipartite_assignment_unit #(.MAX_PAIRS(MAX_PAIRS)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    value_t  first_vals [MAX_PAIRS];
    value_t  second_vals[MAX_PAIRS];
    int      batch_len;
    bit      batch_ovf;
    total_t  pending_totals[$];

    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;
    int      quiet_cycles;
    int      items_sent;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sort both sides descending, then play the classic two-pointer race.
    function automatic logic [SCORE_W-1:0] best_total(input int n);
        int a[MAX_PAIRS];
        int b[MAX_PAIRS];
        int t, i, j, ah, at, bh, bt, net;
        for (i = 0; i < n; i++)
        begin
            a[i] = first_vals[i];
            b[i] = second_vals[i];
        end
        for (i = 1; i < n; i++)
        begin
            for (j = i; j > 0 && a[j] > a[j-1]; j--)
            begin
                t = a[j]; a[j] = a[j-1]; a[j-1] = t;
            end
            for (j = i; j > 0 && b[j] > b[j-1]; j--)
            begin
                t = b[j]; b[j] = b[j-1]; b[j-1] = t;
            end
        end
        ah = 0; at = n - 1; bh = 0; bt = n - 1; net = 0;
        while (ah <= at)
        begin
            if (a[ah] > b[bh])
            begin
                net++; ah++; bh++;
            end
            else if (a[at] > b[bt])
            begin
                net++; at--; bt--;
            end
            else
            begin
                // sacrifice the weakest against the strongest
                if (a[at] < b[bh])
                    net--;
                at--; bh++;
            end
        end
        return SCORE_W'(n + net);
    endfunction

    task automatic absorb_request(input value_t fv, input value_t sv, input bit last,
                                  input bit typed, input total_t want);
        total_t got;
        if (batch_len < MAX_PAIRS)
        begin
            first_vals[batch_len]  = fv;
            second_vals[batch_len] = sv;
            batch_len++;
        end
        else
            batch_ovf = 1'b1;
        if (last)
        begin
            got.score = best_total(batch_len);
            got.ovf   = batch_ovf;
            if (typed && got != want)
                report("table row", int'(got), int'(want));
            pending_totals = {pending_totals, (typed ? want : got)};
            batch_len = 0;
            batch_ovf = 1'b0;
        end
    endtask

    task automatic send_request(input value_t fv, input value_t sv, input bit last,
                                input bit typed, input total_t want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sv, fv};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_request(fv, sv, last, typed, want);
        items_sent++;
    endtask

    task automatic send_batch();
        int     n;
        int     k;
        value_t mask;
        total_t none;
        none = '0;
        n = ($urandom_range(19) == 0) ? $urandom_range(MAX_PAIRS + 6, MAX_PAIRS - 2)
                                      : $urandom_range(12, 1);
        case ($urandom_range(2))
            0: mask = 16'h0003;
            1: mask = 16'h00ff;
            default: mask = 16'hffff;
        endcase
        for (k = 0; k < n; k++)
            send_request(value_t'($urandom) & mask, value_t'($urandom) & mask,
                         k == n - 1, 1'b0, none);
    endtask

    // receiver: random stall plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_totals.size() == 0)
                report("unexpected total", int'(m_axis_tdata[SCORE_W-1:0]), -1);
            else
            begin
                total_t want;
                want = pending_totals.pop_front();
                if (m_axis_tdata[SCORE_W-1:0] !== want.score)
                    report("total_score", int'(m_axis_tdata[SCORE_W-1:0]),
                           int'(want.score));
                if (m_axis_tdata[8] !== want.ovf)
                    report("overflow", int'(m_axis_tdata[8]), int'(want.ovf));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    stim_row_t dir_rows[$];

    function automatic stim_row_t row(input value_t fv, input value_t sv, input bit last,
                                      input bit typed, input int score, input bit ovf);
        stim_row_t r;
        r.fv = fv; r.sv = sv; r.last = last; r.typed = typed;
        r.want.score = SCORE_W'(score);
        r.want.ovf   = ovf;
        return r;
    endfunction

    initial
    begin
        int p, k;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        batch_len      = 0;
        batch_ovf      = 1'b0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single pairs: win, lose, tie at the extremes
        dir_rows = {dir_rows, row(16'hffff, 16'h0000, 1, 1, 2, 0)};
        dir_rows = {dir_rows, row(16'h0000, 16'hffff, 1, 1, 0, 0)};
        dir_rows = {dir_rows, row(16'h0000, 16'h0000, 1, 1, 1, 0)};
        dir_rows = {dir_rows, row(16'hffff, 16'hffff, 1, 1, 1, 0)};
        dir_rows = {dir_rows, row(16'h5555, 16'haaaa, 1, 1, 0, 0)};
        dir_rows = {dir_rows, row(16'haaaa, 16'h5555, 1, 1, 2, 0)};
        // two pairs where a swap beats the given order
        dir_rows = {dir_rows, row(16'd1, 16'd2, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd3, 16'd0, 1, 1, 4, 0)};
        // ties where sacrificing gains
        dir_rows = {dir_rows, row(16'd5, 16'd5, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd3, 16'd3, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd1, 16'd1, 1, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd7, 16'd9, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd9, 16'd7, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'd8, 16'd8, 0, 0, 0, 0)};
        dir_rows = {dir_rows, row(16'hfffe, 16'h0001, 1, 0, 0, 0)};
        foreach (dir_rows[k])
            send_request(dir_rows[k].fv, dir_rows[k].sv, dir_rows[k].last,
                         dir_rows[k].typed, dir_rows[k].want);

        // too many pairs: all equal, so stored 64 tie and overflow is flagged
        for (k = 0; k <= MAX_PAIRS; k++)
            send_request(16'h1234, 16'h1234, k == MAX_PAIRS, k == MAX_PAIRS,
                         total_t'({8'd64, 1'b1}));

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (p == 2)
                hold_cycles = 600;
            k = items_sent;
            while (items_sent - k < 400)
                send_batch();
            if (p == 1)
            begin
                s_axis_tvalid <= 1'b0;
                wait (pending_totals.size() == 0);
                @(posedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_totals.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
